// ===== rtl/core/integer_to_radix_ascii_core_defines.svh =====
// assertion macros for the radix text converter
// no dependencies; included by the top level
`ifndef INTEGER_TO_RADIX_ASCII_CORE_DEFINES_SVH
`define INTEGER_TO_RADIX_ASCII_CORE_DEFINES_SVH

// same-cycle implication under the active-low reset
`define ITRA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("itra: check failed");

// next-cycle implication under the active-low reset
`define ITRA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("itra: check failed");

`endif

// ===== rtl/core/itra_pkg.sv =====
// shared types, constants and helpers of the radix text converter
// no dependencies
package itra_pkg;

  localparam int MagW   = 32;
  localparam int CharW  = 8;
  localparam int DigW   = 6;
  localparam int CfgIdxW = 1;
  localparam int CfgDataW = 6;

  localparam logic [CharW-1:0] MinusChar = 8'h2D;
  localparam logic [CharW-1:0] ZeroChar  = 8'h30;
  localparam logic [CharW-1:0] UpperA    = 8'h41;
  localparam logic [CharW-1:0] LowerA    = 8'h61;
  localparam logic [DigW-1:0]  RadixMin  = 6'd2;
  localparam logic [DigW-1:0]  RadixMax  = 6'd36;
  localparam logic [DigW-1:0]  RadixReset = 6'd10;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_RADIX = 1'b0,
    CFG_UPPER = 1'b1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_DIGITS
  } itra_state_e;

  // clamp the radix register into 2..36
  function automatic logic [DigW-1:0] eff_radix(input logic [DigW-1:0] r);
    logic [DigW-1:0] res;
    if (r < RadixMin) begin
      res = RadixMin;
    end else if (r > RadixMax) begin
      res = RadixMax;
    end else begin
      res = r;
    end
    return res;
  endfunction

  // digit value to ascii symbol
  function automatic logic [CharW-1:0] digit_char(input logic [DigW-1:0] d,
                                                  input logic upper);
    logic [CharW-1:0] res;
    if (d < 6'd10) begin
      res = ZeroChar + {2'b00, d};
    end else begin
      res = (upper ? UpperA : LowerA) + {2'b00, d} - 8'd10;
    end
    return res;
  endfunction

endpackage

// ===== rtl/core/itra_if.sv =====
// valid/ready channel interfaces for input and result items
// depends on itra_pkg
interface itra_in_if;
  import itra_pkg::*;
  logic            valid;
  logic            ready;
  logic [MagW-1:0] magnitude;
  logic            negative;

  modport source (output valid, output magnitude, output negative, input ready);
  modport sink (input valid, input magnitude, input negative, output ready);
endinterface

interface itra_out_if;
  import itra_pkg::*;
  logic             valid;
  logic             ready;
  logic [CharW-1:0] character;
  logic             last;

  modport source (output valid, output character, output last, input ready);
  modport sink (input valid, input character, input last, output ready);
endinterface

// ===== rtl/core/integer_to_radix_ascii_core.sv =====
// Radix text converter. Takes an unsigned magnitude and a sign flag and emits
// its ASCII text in the configured radix (2..36), '-' first when negative,
// digits most significant first, last character marked. The magnitude is
// shifted bit-serially, MSB first, into a row of digit cells that each double
// their digit and add the carry of the cell below, with carries registered
// between cells. B = min(VALUE_BITS, 32) input bits are shifted in and the row
// has N = B digit cells; once the carry has travelled the row, the row is
// shifted out one digit per cycle while the result register is free, leading
// zeros skipped. A waiting result that blocks the result register holds the
// shifting. The '-' is sent while the conversion runs when the result register
// is free, else before the first digit. One item is in work at a time.
// depends on itra_pkg, itra_if and integer_to_radix_ascii_core_defines.svh
`include "integer_to_radix_ascii_core_defines.svh"

module integer_to_radix_ascii_core #(
  parameter int VALUE_BITS = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [itra_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [itra_pkg::CfgDataW-1:0] cfg_data_i,
  itra_in_if.sink                       in_i,
  itra_out_if.source                    out_o
);
  import itra_pkg::*;

  localparam int UsedBits = (VALUE_BITS < MagW) ? VALUE_BITS : MagW;
  localparam int NDig     = UsedBits;
  localparam int CntW     = $clog2(UsedBits + 1);
  localparam int RemW     = $clog2(NDig + 1);

  // configuration registers
  logic [DigW-1:0] radix_q;
  logic            upper_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q <= RadixReset;
      upper_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_RADIX: radix_q <= cfg_data_i;
        CFG_UPPER: upper_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  logic [DigW-1:0] radix_eff;
  assign radix_eff = eff_radix(radix_q);

  // control state
  itra_state_e state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [RemW-1:0] rem_q, rem_d;
  logic            sign_q, sign_d;
  logic            started_q, started_d;
  logic [NDig-1:0] en_q;

  // datapath registers
  logic [UsedBits-1:0] val_q;
  logic [DigW-1:0]     dig_q [NDig];
  logic [NDig-1:0]     carry_q;

  // output register
  logic             out_valid_q;
  logic [CharW-1:0] out_char_q;
  logic             out_last_q;

  logic             in_acc, slot_free, load_out, shift_row, en0;
  logic [CharW-1:0] load_char;
  logic             load_last;

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;
  assign slot_free  = !out_valid_q || out_o.ready;
  assign en0        = (state_q == ST_CONV) && (cnt_q != CntW'(UsedBits));

  // digit cells: d = 2d + carry_in, reduced by the radix
  logic [DigW-1:0] cell_d  [NDig];
  logic [NDig-1:0] cell_c;
  logic [NDig-1:0] cell_en;

  always_comb begin
    for (int i = 0; i < NDig; i++) begin
      logic [DigW:0] t;
      logic          cin;
      if (i == 0) begin
        cin        = val_q[UsedBits-1];
        cell_en[i] = en0;
      end else begin
        cin        = carry_q[i-1];
        cell_en[i] = en_q[i-1];
      end
      t         = {dig_q[i], cin};
      cell_c[i] = (t >= {1'b0, radix_eff});
      cell_d[i] = cell_c[i] ? DigW'(t - {1'b0, radix_eff}) : DigW'(t);
    end
  end

  // next state and result selection
  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    rem_d     = rem_q;
    sign_d    = sign_q;
    started_d = started_q;
    load_out  = 1'b0;
    load_char = MinusChar;
    load_last = 1'b0;
    shift_row = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          state_d   = ST_CONV;
          cnt_d     = '0;
          rem_d     = RemW'(NDig);
          sign_d    = in_i.negative;
          started_d = 1'b0;
        end
      end
      ST_CONV: begin
        if (en0) begin
          cnt_d = cnt_q + 1'b1;
        end
        if (sign_q && slot_free) begin
          load_out = 1'b1;
          sign_d   = 1'b0;
        end
        // top cell just did its final update
        if (en_q[NDig-1] && !cell_en[NDig-1]) begin
          state_d = ST_DIGITS;
        end
      end
      ST_DIGITS: begin
        if (sign_q) begin
          if (slot_free) begin
            load_out = 1'b1;
            sign_d   = 1'b0;
          end
        end else if (started_q || (dig_q[NDig-1] != '0) || (rem_q == RemW'(1))) begin
          if (slot_free) begin
            load_out  = 1'b1;
            load_char = digit_char(dig_q[NDig-1], upper_q);
            load_last = (rem_q == RemW'(1));
            shift_row = 1'b1;
            started_d = 1'b1;
            rem_d     = rem_q - 1'b1;
            if (rem_q == RemW'(1)) begin
              state_d = ST_IDLE;
            end
          end
        end else begin
          // leading zero, dropped
          shift_row = 1'b1;
          rem_d     = rem_q - 1'b1;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_q     <= '0;
      rem_q     <= '0;
      sign_q    <= 1'b0;
      started_q <= 1'b0;
      en_q      <= '0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      rem_q     <= rem_d;
      sign_q    <= sign_d;
      started_q <= started_d;
      en_q      <= in_acc ? '0 : cell_en;
    end
  end

  // value shifter and digit row
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      val_q   <= in_i.magnitude[UsedBits-1:0];
      carry_q <= '0;
      for (int i = 0; i < NDig; i++) begin
        dig_q[i] <= '0;
      end
    end else if (state_q == ST_CONV) begin
      val_q   <= val_q << 1;
      carry_q <= cell_c;
      for (int i = 0; i < NDig; i++) begin
        if (cell_en[i]) begin
          dig_q[i] <= cell_d[i];
        end
      end
    end else if (shift_row) begin
      dig_q[0] <= '0;
      for (int i = 1; i < NDig; i++) begin
        dig_q[i] <= dig_q[i-1];
      end
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_char_q <= load_char;
      out_last_q <= load_last;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.character = out_char_q;
  assign out_o.last      = out_last_q;

  // checks
  `ITRA_ASSERT_NEXT(a_acc_starts_conv, clk_i, rst_ni, in_acc, state_q == ST_CONV && en_q == '0)
  `ITRA_ASSERT_NEXT(a_last_ends_item, clk_i, rst_ni, load_out && load_last, state_q == ST_IDLE)
  `ITRA_ASSERT_NOW(a_digits_pending, clk_i, rst_ni, state_q == ST_DIGITS, rem_q != '0)
  `ITRA_ASSERT_NEXT(a_out_held, clk_i, rst_ni, out_valid_q && !out_o.ready, out_valid_q && $stable(out_char_q) && $stable(out_last_q))

endmodule
